>>> rtl/core/hpnt_pkg.sv
// ----------------------------------------------------------------------------
// hpnt_pkg
// Types and constants shared by the held pad and note tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hpnt_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] NO_NOTE     = 8'd128;
    localparam logic [7:0] NO_PRESSURE = 8'd128;
    localparam logic [4:0] NO_CHANNEL  = 5'd16;
    localparam logic [2:0] SRC_MIDI    = 3'd0;

    typedef enum logic [3:0] {
        K_PAD_PRESS  = 4'd0,
        K_PAD_TOUCH  = 4'd1,
        K_PAD_REL    = 4'd2,
        K_PRG_PRESS  = 4'd3,
        K_PRG_TOUCH  = 4'd4,
        K_PRG_REL    = 4'd5,
        K_NOTE_ON    = 4'd6,
        K_NOTE_TOUCH = 4'd7,
        K_NOTE_OFF   = 4'd8,
        K_CLEAR      = 4'd9
    } t_kind;

    typedef enum logic [1:0] {
        TBL_PAD  = 2'd0,
        TBL_PRG  = 2'd1,
        TBL_NOTE = 2'd2
    } t_tbl;

    typedef enum logic [2:0] {
        OP_PRESS = 3'd0,
        OP_TOUCH = 3'd1,
        OP_REL   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_NONE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_START  = 2'd1,
        S_SCAN   = 2'd2,
        S_FINISH = 2'd3
    } t_state;

    typedef struct packed {
        logic [2:0] source;
        logic [6:0] key;
        logic [7:0] note;
        logic [6:0] vel;
        logic [7:0] press;
        logic [4:0] chan;
        logic [4:0] prog;
        logic [5:0] track;
        logic [2:0] bus;
        logic [1:0] bank;
    } t_entry;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] source;
        logic [6:0] key;
        logic [7:0] note_number;
        logic [6:0] velocity;
        logic [6:0] pressure;
        logic [4:0] midi_channel;
        logic [4:0] program_req;
        logic [5:0] track;
        logic [2:0] bus;
        logic [1:0] bank;
    } t_req;

    typedef struct packed {
        logic   found;
        logic   last;
        t_entry ent;
    } t_res;

    typedef struct packed {
        logic push;
        logic shift;
        logic take_fb;
    } t_cell_ctl;

    typedef struct packed {
        logic push;
        logic step;
        logic keep;
        logic clr;
    } t_row_op;

endpackage

`default_nettype wire

>>> rtl/core/hpnt_in_if.sv
// ----------------------------------------------------------------------------
// hpnt_in_if
// Event channel: one beat carries one pad, program pad, note or clear event.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpnt_in_if import hpnt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [2:0] src;
    logic [6:0] key;
    logic [7:0] note_number;
    logic [6:0] velocity;
    logic [6:0] pressure;
    logic [4:0] midi_channel;
    logic [4:0] program_req;
    logic [5:0] track;
    logic [2:0] bus;
    logic [1:0] bank;

    modport source (
        output valid, kind, src, key, note_number, velocity, pressure,
               midi_channel, program_req, track, bus, bank,
        input  ready
    );
    modport sink (
        input  valid, kind, src, key, note_number, velocity, pressure,
               midi_channel, program_req, track, bus, bank,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/hpnt_out_if.sv
// ----------------------------------------------------------------------------
// hpnt_out_if
// Result channel: one beat reports one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpnt_out_if import hpnt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       found;
    logic       last;
    logic [2:0] source_res;
    logic [6:0] key_res;
    logic [7:0] note_number_res;
    logic [6:0] velocity_res;
    logic [7:0] pressure_res;
    logic [4:0] midi_channel_res;
    logic [4:0] program_res;
    logic [5:0] track_res;
    logic [2:0] bus_res;
    logic [1:0] bank_res;

    modport source (
        output valid, found, last, source_res, key_res, note_number_res,
               velocity_res, pressure_res, midi_channel_res, program_res,
               track_res, bus_res, bank_res,
        input  ready
    );
    modport sink (
        input  valid, found, last, source_res, key_res, note_number_res,
               velocity_res, pressure_res, midi_channel_res, program_res,
               track_res, bus_res, bank_res,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/hpnt_cell.sv
// ----------------------------------------------------------------------------
// hpnt_cell
// One table slot: loads a pushed entry, its neighbor's entry or the head
// entry fed back to the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module hpnt_cell import hpnt_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_nbr,
    input  t_entry    i_fb,
    input  t_entry    i_push,
    output t_entry    o_ent
);

    t_entry r_ent;
    t_entry n_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.push) begin
            n_ent = i_push;
        end else if (i_ctl.shift) begin
            n_ent = i_ctl.take_fb ? i_fb : i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

>>> rtl/core/hpnt_row.sv
// ----------------------------------------------------------------------------
// hpnt_row
// Ordered table as a row of cells with a fill count; rotates toward the head
// one entry per step, dropping the head or returning it to the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module hpnt_row import hpnt_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_row_op       i_op,
    input  t_entry        i_push,
    input  t_entry        i_fb,
    output t_entry        o_head,
    output logic [CW-1:0] o_count,
    output logic          o_full
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_entry        w_ent [DEPTH];
    t_cell_ctl     w_ctl [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_nbr;

        if (g == DEPTH - 1) begin : g_top
            assign w_nbr = i_fb;
        end else begin : g_mid
            assign w_nbr = w_ent[g+1];
        end

        assign w_ctl[g].push    = i_op.push && (r_count == CW'(g));
        assign w_ctl[g].shift   = i_op.step;
        assign w_ctl[g].take_fb = i_op.keep && (r_count == CW'(g + 1));

        hpnt_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_nbr  (w_nbr),
            .i_fb   (i_fb),
            .i_push (i_push),
            .o_ent  (w_ent[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_op.clr) begin
            n_count = '0;
        end else if (i_op.push) begin
            n_count = r_count + CW'(1);
        end else if (i_op.step && !i_op.keep) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_ent[0];
    assign o_count = r_count;
    assign o_full  = (r_count == CW'(DEPTH));

endmodule

`default_nettype wire

>>> rtl/core/held_pad_and_note_tracker.sv
// ----------------------------------------------------------------------------
// held_pad_and_note_tracker
// Tracks held physical pads, program pads and notes in three ordered tables.
// ----------------------------------------------------------------------------
// Usage:
//   i_evt carries one event per beat (press, aftertouch, release for each of
//   the three tables, or clear). o_res carries one beat per reported entry;
//   last marks the final beat of an event.
//   One event is processed at a time; i_evt.ready is high only while idle.
//   Press: result registered in the start state once the output is free.
//   Aftertouch and release: the selected table rotates through its row of
//   cells, one entry per cycle past the head compare unless a result waits,
//   once for each of the N held entries in that table (N up to TABLE_DEPTH).
//   Aftertouch gives one beat per match (at most 16) or none; release gives
//   exactly one beat. Clear and unused kinds give no result.
//   Reset empties all three tables and clears the result valid flag.
//   A stalled receiver holds the result register; the rotation waits while
//   a new result cannot be placed, and no result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module held_pad_and_note_tracker import hpnt_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hpnt_in_if.sink           i_evt,
    hpnt_out_if.source        o_res
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state              r_state, n_state;
    t_req                r_req, n_req;
    t_tbl                r_tbl, n_tbl;
    t_op                 r_op, n_op;
    logic [CW-1:0]       r_left, n_left;
    logic                r_hit, n_hit;
    logic                r_pend_v, n_pend_v;
    t_entry              r_pend, n_pend;
    logic [RES_CNT_W-1:0] r_nrep, n_nrep;
    logic                r_out_v, n_out_v;
    t_res                r_out, n_out;

    t_row_op             w_op    [3];
    t_entry              w_head  [3];
    logic [CW-1:0]       w_count [3];
    logic                w_full  [3];
    t_entry              w_fb;
    t_entry              w_press_ent;
    t_entry              w_sel_head;
    logic [CW-1:0]       w_sel_count;
    logic                w_sel_full;
    logic                w_accept;
    logic                w_out_free;
    logic                w_match;
    logic                w_cap_ok;
    logic                w_need_out;
    logic                w_fin_emit;

    for (genvar t = 0; t < 3; t++) begin : g_row
        hpnt_row #(.DEPTH(TABLE_DEPTH)) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (w_op[t]),
            .i_push  (w_press_ent),
            .i_fb    (w_fb),
            .o_head  (w_head[t]),
            .o_count (w_count[t]),
            .o_full  (w_full[t])
        );
    end

    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_out_free  = !r_out_v || o_res.ready;
    assign w_sel_head  = w_head[r_tbl];
    assign w_sel_count = w_count[r_tbl];
    assign w_sel_full  = w_full[r_tbl];
    assign w_cap_ok    = (r_nrep < RES_CNT_W'(MAX_RESULTS));

    always_comb begin
        w_press_ent.source = r_req.source;
        w_press_ent.key    = r_req.key;
        w_press_ent.note   = (r_tbl == TBL_PAD) ? r_req.note_number : NO_NOTE;
        w_press_ent.vel    = r_req.velocity;
        w_press_ent.press  = NO_PRESSURE;
        w_press_ent.chan   = (r_tbl == TBL_PAD) ? NO_CHANNEL : r_req.midi_channel;
        w_press_ent.prog   = r_req.program_req;
        w_press_ent.track  = r_req.track;
        w_press_ent.bus    = r_req.bus;
        w_press_ent.bank   = (r_tbl == TBL_PAD) ? r_req.bank : 2'd0;
    end

    always_comb begin
        logic key_eq, src_eq, chan_eq, prg_eq;
        key_eq  = (w_sel_head.key == r_req.key);
        src_eq  = (w_sel_head.source == r_req.source);
        chan_eq = (w_sel_head.chan == r_req.midi_channel);
        prg_eq  = (w_sel_head.prog == r_req.program_req);
        w_match = 1'b0;
        if (r_op == OP_TOUCH) begin
            w_match = key_eq && src_eq && ((r_tbl != TBL_NOTE) || chan_eq);
        end else if (r_op == OP_REL) begin
            unique case (r_tbl)
                TBL_PAD:  w_match = key_eq;
                TBL_PRG:  w_match = key_eq && src_eq && prg_eq;
                TBL_NOTE: w_match = key_eq && src_eq &&
                                    ((w_sel_head.source != SRC_MIDI) || chan_eq);
                default:  w_match = 1'b0;
            endcase
        end
    end

    assign w_need_out = (r_op == OP_TOUCH) ? (w_match && w_cap_ok && r_pend_v)
                                           : (w_match && !r_hit);
    assign w_fin_emit = ((r_op == OP_TOUCH) && r_pend_v) ||
                        ((r_op == OP_REL) && !r_hit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_START;
            end
            S_START: begin
                unique case (r_op)
                    OP_PRESS: if (w_out_free) n_state = S_IDLE;
                    OP_TOUCH, OP_REL: n_state = S_SCAN;
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (r_left == '0) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!w_fin_emit || w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req    = r_req;
        n_tbl    = r_tbl;
        n_op     = r_op;
        n_left   = r_left;
        n_hit    = r_hit;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_nrep   = r_nrep;
        n_out_v  = r_out_v && !o_res.ready;
        n_out    = r_out;
        w_fb     = w_sel_head;
        for (int t = 0; t < 3; t++) begin
            w_op[t] = '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req.kind         = t_kind'(i_evt.kind);
                    n_req.source       = i_evt.src;
                    n_req.key          = i_evt.key;
                    n_req.note_number  = i_evt.note_number;
                    n_req.velocity     = i_evt.velocity;
                    n_req.pressure     = i_evt.pressure;
                    n_req.midi_channel = i_evt.midi_channel;
                    n_req.program_req  = i_evt.program_req;
                    n_req.track        = i_evt.track;
                    n_req.bus          = i_evt.bus;
                    n_req.bank         = i_evt.bank;
                    unique case (t_kind'(i_evt.kind))
                        K_PAD_PRESS:  begin n_op = OP_PRESS; n_tbl = TBL_PAD;  end
                        K_PAD_TOUCH:  begin n_op = OP_TOUCH; n_tbl = TBL_PAD;  end
                        K_PAD_REL:    begin n_op = OP_REL;   n_tbl = TBL_PAD;  end
                        K_PRG_PRESS:  begin n_op = OP_PRESS; n_tbl = TBL_PRG;  end
                        K_PRG_TOUCH:  begin n_op = OP_TOUCH; n_tbl = TBL_PRG;  end
                        K_PRG_REL:    begin n_op = OP_REL;   n_tbl = TBL_PRG;  end
                        K_NOTE_ON:    begin n_op = OP_PRESS; n_tbl = TBL_NOTE; end
                        K_NOTE_TOUCH: begin n_op = OP_TOUCH; n_tbl = TBL_NOTE; end
                        K_NOTE_OFF:   begin n_op = OP_REL;   n_tbl = TBL_NOTE; end
                        K_CLEAR:      begin n_op = OP_CLEAR; n_tbl = TBL_PAD;  end
                        default:      begin n_op = OP_NONE;  n_tbl = TBL_PAD;  end
                    endcase
                end
            end
            S_START: begin
                unique case (r_op)
                    OP_PRESS: begin
                        if (w_out_free) begin
                            w_op[r_tbl].push = !w_sel_full;
                            n_out_v          = 1'b1;
                            n_out.found      = !w_sel_full;
                            n_out.last       = 1'b1;
                            n_out.ent        = w_press_ent;
                        end
                    end
                    OP_TOUCH, OP_REL: begin
                        n_left   = w_sel_count;
                        n_hit    = 1'b0;
                        n_pend_v = 1'b0;
                        n_nrep   = '0;
                    end
                    OP_CLEAR: begin
                        for (int t = 0; t < 3; t++) begin
                            w_op[t].clr = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if ((r_left != '0) && (!w_need_out || w_out_free)) begin
                    if ((r_op == OP_TOUCH) && w_match) begin
                        w_fb.press = {1'b0, r_req.pressure};
                    end
                    w_op[r_tbl].step = 1'b1;
                    w_op[r_tbl].keep = !((r_op == OP_REL) && w_match && !r_hit);
                    n_left           = r_left - CW'(1);
                    if ((r_op == OP_TOUCH) && w_match && w_cap_ok) begin
                        if (r_pend_v) begin
                            n_out_v     = 1'b1;
                            n_out.found = 1'b1;
                            n_out.last  = 1'b0;
                            n_out.ent   = r_pend;
                        end
                        n_pend   = w_fb;
                        n_pend_v = 1'b1;
                        n_nrep   = r_nrep + RES_CNT_W'(1);
                    end
                    if ((r_op == OP_REL) && w_match && !r_hit) begin
                        n_hit       = 1'b1;
                        n_out_v     = 1'b1;
                        n_out.found = 1'b1;
                        n_out.last  = 1'b1;
                        n_out.ent   = w_sel_head;
                    end
                end
            end
            S_FINISH: begin
                if (w_fin_emit && w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out.last = 1'b1;
                    if (r_op == OP_TOUCH) begin
                        n_out.found = 1'b1;
                        n_out.ent   = r_pend;
                        n_pend_v    = 1'b0;
                    end else begin
                        n_out.found = 1'b0;
                        n_out.ent   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tbl    <= TBL_PAD;
            r_op     <= OP_NONE;
            r_left   <= '0;
            r_hit    <= 1'b0;
            r_pend_v <= 1'b0;
            r_nrep   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tbl    <= n_tbl;
            r_op     <= n_op;
            r_left   <= n_left;
            r_hit    <= n_hit;
            r_pend_v <= n_pend_v;
            r_nrep   <= n_nrep;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign i_evt.ready            = (r_state == S_IDLE);
    assign o_res.valid            = r_out_v;
    assign o_res.found            = r_out.found;
    assign o_res.last             = r_out.last;
    assign o_res.source_res       = r_out.ent.source;
    assign o_res.key_res          = r_out.ent.key;
    assign o_res.note_number_res  = r_out.ent.note;
    assign o_res.velocity_res     = r_out.ent.vel;
    assign o_res.pressure_res     = r_out.ent.press;
    assign o_res.midi_channel_res = r_out.ent.chan;
    assign o_res.program_res      = r_out.ent.prog;
    assign o_res.track_res        = r_out.ent.track;
    assign o_res.bus_res          = r_out.ent.bus;
    assign o_res.bank_res         = r_out.ent.bank;

endmodule

`default_nettype wire

>>> rtl/core/hpnt_checker.sv
// ----------------------------------------------------------------------------
// hpnt_checker
// Port-level checks for the held pad and note tracker, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hpnt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_found,
    input logic       i_out_last,
    input logic [6:0] i_out_key,
    input logic [7:0] i_out_press
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_key) && $stable(i_out_press) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("event accepted while another is in progress");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_last)
        else $error("found-clear beat not marked last");

endmodule

bind held_pad_and_note_tracker hpnt_checker u_hpnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_evt.valid),
    .i_in_ready  (i_evt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_found (o_res.found),
    .i_out_last  (o_res.last),
    .i_out_key   (o_res.key_res),
    .i_out_press (o_res.pressure_res)
);

`default_nettype wire
